// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OGRU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OGRU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ogru_pkg.sv
// Shared types, codes and constants of the occupancy grid ray update block.
// No dependencies; every module of the block imports it.
package ogru_pkg;

  localparam int DEF_GRID_WIDTH  = 128;
  localparam int DEF_GRID_HEIGHT = 128;

  localparam int COORD_W   = 11;
  localparam int CELL_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;

  typedef logic signed [CELL_W-1:0]  cell_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam cfg_idx_t CFG_FREE_STEP     = 3'd0;
  localparam cfg_idx_t CFG_OCCUPIED_STEP = 3'd1;
  localparam cfg_idx_t CFG_FLOOR_VALUE   = 3'd2;
  localparam cfg_idx_t CFG_CEILING_VALUE = 3'd3;

  localparam status_t ST_DONE         = 2'd0;
  localparam status_t ST_RAY_REJECTED = 2'd1;
  localparam status_t ST_READ_OUTSIDE = 2'd2;

  localparam logic ACT_RAY  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam cell_t FREE_STEP_RST     = -5'sd2;
  localparam cell_t OCCUPIED_STEP_RST = 5'sd6;
  localparam cell_t FLOOR_VALUE_RST   = -5'sd4;
  localparam cell_t CEILING_VALUE_RST = 5'sd12;
  localparam cell_t CELL_RST          = -5'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_wr;
    logic    load;
    logic    rd_start;
    logic    walk;
    logic    mark;
    logic    res_load;
    status_t res_code;
    logic    res_from_mem;
  } ogru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic start_in;
    logic end_in;
    logic at_end;
    logic mark;
  } ogru_stat_t;

endpackage

// File: rtl/core/ogru_ctrl.sv
// Controller state machine of the occupancy grid ray update block.
// Depends on ogru_pkg; drives the datapath through ogru_cmd_t.
module ogru_ctrl import ogru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output ogru_cmd_t  cmd,
  input  ogru_stat_t stat
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_WALK   = 6'b001000,
    S_FIN    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t res_code, res_code_next;
  logic    res_mem, res_mem_next;
  logic    out_valid_next;
  logic    res_free;

  assign res_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    res_mem_next  = res_mem;
    cmd           = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_read) begin
          if (stat.start_in) begin
            cmd.rd_start  = 1'b1;
            res_code_next = ST_DONE;
            res_mem_next  = 1'b1;
            state_next    = S_FIN;
          end else begin
            res_code_next = ST_READ_OUTSIDE;
            res_mem_next  = 1'b0;
            state_next    = S_DONE;
          end
        end else if (!stat.start_in || !stat.end_in) begin
          res_code_next = ST_RAY_REJECTED;
          res_mem_next  = 1'b0;
          state_next    = S_DONE;
        end else begin
          res_code_next = ST_DONE;
          res_mem_next  = 1'b0;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat.at_end) begin
          cmd.walk = 1'b1;
        end else begin
          cmd.mark   = stat.mark;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.res_code     = res_code;
    cmd.res_from_mem = res_mem;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_code  <= ST_DONE;
      res_mem   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      res_mem   <= res_mem_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/ogru_datapath.sv
// Datapath of the occupancy grid ray update block: cell memory, line stepper,
// saturating update, configuration and result registers. Depends on ogru_pkg.
module ogru_datapath import ogru_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  cfg_idx_t   cfg_index,
  input  cell_t      cfg_data,
  input  logic       action,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  input  logic       mark_occupied,
  input  ogru_cmd_t  cmd,
  output ogru_stat_t stat,
  output cell_t      cell_value,
  output status_t    status
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = 2 * COORD_W;

  typedef logic [AW-1:0] addr_t;

  function automatic logic in_grid(input coord_t c, input int lim);
    return !c[COORD_W-1] && ($unsigned(c) < COORD_W'(lim));
  endfunction

  function automatic addr_t cell_addr(input coord_t x, input coord_t y);
    logic [PW-1:0] full;
    full = PW'(y[COORD_W-2:0]) * PW'(GRID_WIDTH) + PW'(x[COORD_W-2:0]);
    return full[AW-1:0];
  endfunction

  // Configuration.
  cell_t free_step, occupied_step, floor_value, ceiling_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_step     <= FREE_STEP_RST;
      occupied_step <= OCCUPIED_STEP_RST;
      floor_value   <= FLOOR_VALUE_RST;
      ceiling_value <= CEILING_VALUE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_FREE_STEP:     free_step     <= cfg_data;
        CFG_OCCUPIED_STEP: occupied_step <= cfg_data;
        CFG_FLOOR_VALUE:   floor_value   <= cfg_data;
        CFG_CEILING_VALUE: ceiling_value <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Item and line stepper registers.
  logic                      act, mark_r, sx_neg, sy_neg;
  coord_t                    cx, cy, ex, ey;
  logic [COORD_W-1:0]        dx, dy;
  logic signed [COORD_W:0]   err;

  logic signed [COORD_W:0]   ddx, ddy;
  logic [COORD_W:0]          adx, ady;
  logic signed [COORD_W+1:0] e2, err_wide;
  logic                      step_x, step_y;

  always_comb begin
    ddx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    ddy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    adx = ddx[COORD_W] ? $unsigned(-ddx) : $unsigned(ddx);
    ady = ddy[COORD_W] ? $unsigned(-ddy) : $unsigned(ddy);

    e2       = {err, 1'b0};
    step_x   = e2 > -$signed({2'b00, dy});
    step_y   = e2 < $signed({2'b00, dx});
    err_wide = {err[COORD_W], err}
             - (step_x ? $signed({2'b00, dy}) : '0)
             + (step_y ? $signed({2'b00, dx}) : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action;
      mark_r <= mark_occupied;
      cx     <= start_x;
      cy     <= start_y;
      ex     <= end_x;
      ey     <= end_y;
      dx     <= adx[COORD_W-1:0];
      dy     <= ady[COORD_W-1:0];
      sx_neg <= !(start_x < end_x);
      sy_neg <= !(start_y < end_y);
      err    <= $signed({1'b0, adx[COORD_W-1:0]}) - $signed({1'b0, ady[COORD_W-1:0]});
    end else if (cmd.walk) begin
      if (step_x) begin
        cx <= sx_neg ? cx - 1'b1 : cx + 1'b1;
      end
      if (step_y) begin
        cy <= sy_neg ? cy - 1'b1 : cy + 1'b1;
      end
      err <= err_wide[COORD_W:0];
    end
  end

  // Cell memory: one read port with registered data, one write port. A read
  // issued for an update is written back in the next cycle; the cells of one
  // ray are all distinct, so no read sees a pending write.
  cell_t mem [CELLS];
  cell_t q;
  addr_t clr_cnt;
  addr_t rd_addr, wr_addr, mem_waddr;
  cell_t wr_step, mem_wdata, upd_value;
  logic  rd_en, wr_pend, mem_we;
  logic signed [CELL_W:0] sum;

  always_comb begin
    rd_en   = cmd.rd_start | cmd.walk | cmd.mark;
    rd_addr = cmd.mark ? cell_addr(ex, ey) : cell_addr(cx, cy);

    // Floor first, then ceiling, so a floor above the ceiling yields the ceiling.
    sum = $signed({q[CELL_W-1], q}) + $signed({wr_step[CELL_W-1], wr_step});
    if (sum < $signed({floor_value[CELL_W-1], floor_value})) begin
      sum = $signed({floor_value[CELL_W-1], floor_value});
    end
    if (sum > $signed({ceiling_value[CELL_W-1], ceiling_value})) begin
      sum = $signed({ceiling_value[CELL_W-1], ceiling_value});
    end
    upd_value = sum[CELL_W-1:0];

    mem_we    = cmd.clear_wr | wr_pend;
    mem_waddr = cmd.clear_wr ? clr_cnt : wr_addr;
    mem_wdata = cmd.clear_wr ? CELL_RST : upd_value;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      clr_cnt <= '0;
    end else begin
      wr_pend <= cmd.walk | cmd.mark;
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= rd_addr;
    wr_step <= cmd.mark ? occupied_step : free_step;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cell_value <= cmd.res_from_mem ? q : '0;
      status     <= cmd.res_code;
    end
  end

  always_comb begin
    stat.clear_last = (clr_cnt == AW'(CELLS - 1));
    stat.is_read    = (act == ACT_READ);
    stat.start_in   = in_grid(cx, GRID_WIDTH) && in_grid(cy, GRID_HEIGHT);
    stat.end_in     = in_grid(ex, GRID_WIDTH) && in_grid(ey, GRID_HEIGHT);
    stat.at_end     = (cx == ex) && (cy == ey);
    stat.mark       = mark_r;
  end

endmodule

// File: rtl/core/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block.
// Depends on ogru_pkg, ogru_ctrl and ogru_datapath.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_stall | action, start_x/y, end_x/y,
//           |           |                     | mark_occupied
//   out     | output    | out_valid/out_stall | cell_value, status
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// After reset the block sweeps all GRID_WIDTH*GRID_HEIGHT cells (16384 at the
// default size) of the cell memory to minus one, one cell a cycle; input stays
// stalled during that pass, while configuration words are taken at once.
// A ray word walks its line from start to end cell, paced by the single memory
// read port: one cell read-modify-write per cycle. A read word and a rejected
// ray skip the walk. A stalled result holds in the output register while the
// block takes the next input word.
module occupancy_grid_ray_update import ogru_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic     clk,
  input  logic     rst,

  // Input words.
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     action,
  input  coord_t   start_x,
  input  coord_t   start_y,
  input  coord_t   end_x,
  input  coord_t   end_y,
  input  logic     mark_occupied,

  // Result words.
  output logic     out_valid,
  input  logic     out_stall,
  output cell_t    cell_value,
  output status_t  status,

  // Configuration writes.
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  cell_t    cfg_data
);

  ogru_cmd_t  cmd;
  ogru_stat_t stat;
  logic       cfg_wr;

  // The register file takes a write in any cycle, including the clearing pass.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // The controller sequences clear, decode, line walk and result hand-off.
  ogru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the grid, the line stepper and the saturating adder.
  ogru_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .mark_occupied (mark_occupied),
    .cmd           (cmd),
    .stat          (stat),
    .cell_value    (cell_value),
    .status        (status)
  );

endmodule

// File: rtl/core/ogru_checker.sv
// Port-level checker of the occupancy grid ray update block, bound to the top.
// Depends on ogru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ogru_checker import ogru_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input cell_t   cell_value,
  input status_t status
);

  // A stalled result word holds.
  `OGRU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(status) && $stable(cell_value), "stalled result changed")

  // Rejected rays and outside reads carry a zero value.
  `OGRU_ASSERT_IMP(a_zero_value, clk, rst, out_valid && (status != ST_DONE),
    cell_value == '0, "non-zero value with a reject status")

  // The block works on one word at a time.
  `OGRU_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall,
    in_stall, "input taken in the cycle after an accept")

  // The clearing pass holds off input right after reset.
  `OGRU_ASSERT_IMP(a_clear_after_reset, clk, rst, $fell(rst),
    in_stall && !out_valid, "input open or result shown after reset")

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);
